@@ rtl/voxel_earliest_step_grid_macros.svh @@
// assertion helpers for the checker file
`ifndef VOXEL_EARLIEST_STEP_GRID_MACROS_SVH
`define VOXEL_EARLIEST_STEP_GRID_MACROS_SVH

// same-cycle implication
`define VESG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VESG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vesg_pkg.sv @@
`default_nettype none
package vesg_pkg;

   localparam int COORD_W   = 12;
   localparam int STEP_IN_W = 32;
   localparam int OUT_W     = 32;
   localparam int REQ_W     = 2;

   localparam int EXT_X_W = 6;
   localparam int EXT_Y_W = 6;
   localparam int EXT_Z_W = 5;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [EXT_X_W-1:0] EXT_X_RESET = EXT_X_W'(32);
   localparam logic [EXT_Y_W-1:0] EXT_Y_RESET = EXT_Y_W'(32);
   localparam logic [EXT_Z_W-1:0] EXT_Z_RESET = EXT_Z_W'(16);

   // request kinds
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RECORD = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_Z = 2'd2;

   typedef struct packed {
      logic is_record;
      logic is_query;
      logic in_grid;
      logic run_end;
   } op_type;

endpackage
`default_nettype wire

@@ rtl/vesg_req_if.sv @@
`default_nettype none
interface vesg_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [vesg_pkg::REQ_W-1:0]           req_type;
   logic signed [vesg_pkg::COORD_W-1:0]  voxel_x;
   logic signed [vesg_pkg::COORD_W-1:0]  voxel_y;
   logic signed [vesg_pkg::COORD_W-1:0]  voxel_z;
   logic [vesg_pkg::STEP_IN_W-1:0]       step_value;
   logic                                 run_end;

   modport source (output valid, req_type, voxel_x, voxel_y, voxel_z, step_value, run_end,
                   input ready);
   modport sink (input valid, req_type, voxel_x, voxel_y, voxel_z, step_value, run_end,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/vesg_rsp_if.sv @@
`default_nettype none
interface vesg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vesg_pkg::OUT_W-1:0]     earliest_step;

   modport source (output valid, earliest_step, input ready);
   modport sink (input valid, earliest_step, output ready);
endinterface
`default_nettype wire

@@ rtl/vesg_csr_if.sv @@
`default_nettype none
interface vesg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [vesg_pkg::CSR_INDEX_W-1:0]    index;
   logic [vesg_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/vesg_store.sv @@
`default_nettype none
module vesg_store #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read-before-write on a shared address
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/vesg_sweep.sv @@
`default_nettype none
module vesg_sweep #(
   parameter int ADDR_W = 14
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic      [ADDR_W-1:0] addr
);

   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end else if (busy_ff) begin
         addr_in = addr_ff + ADDR_W'(1);
         if (addr_ff == {ADDR_W{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule
`default_nettype wire

@@ rtl/vesg_update.sv @@
`default_nettype none
module vesg_update #(
   parameter int ADDR_W    = 14,
   parameter int STEP_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         take,
   input  wire vesg_pkg::op_type             op_in,
   input  wire logic [ADDR_W-1:0]            addr_in,
   input  wire logic [STEP_BITS-1:0]         step_in,
   input  wire logic [STEP_BITS-1:0]         rd_data,
   input  wire logic                         rsp_ready,
   output logic                              can_take,
   output logic                              wr_en,
   output logic      [ADDR_W-1:0]            wr_addr,
   output logic      [STEP_BITS-1:0]         wr_data,
   output logic                              rsp_valid,
   output logic      [vesg_pkg::OUT_W-1:0]   rsp_step
);

   localparam logic [STEP_BITS-1:0] STEP_ONES = {STEP_BITS{1'b1}};

   logic                       s1_valid_ff;
   vesg_pkg::op_type           s1_op_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [STEP_BITS-1:0]       s1_step_ff;

   logic                       fwd_valid_ff;
   logic [ADDR_W-1:0]          fwd_addr_ff;
   logic [STEP_BITS-1:0]       fwd_data_ff;

   logic [STEP_BITS-1:0]       run_min_ff, run_min_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [vesg_pkg::OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [STEP_BITS-1:0]       cur;
   logic [STEP_BITS-1:0]       cand;
   logic [STEP_BITS-1:0]       qmin;
   logic                       do_query;
   logic                       emit;

   // the write retiring on the read edge is not in the read data yet
   assign cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;

   assign wr_en   = s1_valid_ff && s1_op_ff.is_record && s1_op_ff.in_grid
                    && (s1_step_ff < cur);
   assign wr_addr = s1_addr_ff;
   assign wr_data = s1_step_ff;

   assign do_query = s1_valid_ff && s1_op_ff.is_query;
   assign emit     = do_query && s1_op_ff.run_end;
   assign cand     = s1_op_ff.in_grid ? cur : STEP_ONES;
   assign qmin     = (cand < run_min_ff) ? cand : run_min_ff;

   // an accepted item must find the result register free when it leaves
   assign can_take = (!rsp_valid_ff || rsp_ready) && !emit;

   always_comb begin
      run_min_in   = run_min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (do_query) begin
         run_min_in = s1_op_ff.run_end ? STEP_ONES : qmin;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = vesg_pkg::OUT_W'(qmin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         run_min_ff   <= STEP_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= take;
         fwd_valid_ff <= wr_en;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_op_ff    <= op_in;
      s1_addr_ff  <= addr_in;
      s1_step_ff  <= step_in;
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_step  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/voxel_earliest_step_grid.sv @@
// channel  dir  handshake      payload
// req_ch   in   valid/ready    req_type, voxel_x/y/z, step_value, run_end
// rsp_ch   out  valid/ready    earliest_step
// csr_ch   in   valid/ready    index, data (extent_x/y/z), always ready
//
// record items: one read-modify-write of the step memory each; query items: one read each;
// an item may enter every cycle, except in the cycle after a run-ending query item, when intake pauses
// a result passes the item stage register and then the result register after its run-ending query item
// clear, and reset, sweep the memory of 2**(x+y+z address bits) cells one cell a cycle
// (16384 cells at default sizes), no item taken meanwhile
// a result waiting on rsp_ch holds all intake until it is taken
`default_nettype none
module voxel_earliest_step_grid #(
   parameter int MAX_X     = 32,
   parameter int MAX_Y     = 32,
   parameter int MAX_Z     = 16,
   parameter int STEP_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vesg_req_if.sink    req_ch,
   vesg_rsp_if.source  rsp_ch,
   vesg_csr_if.sink    csr_ch
);

   localparam int X_W    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int Y_W    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int Z_W    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int ADDR_W = X_W + Y_W + Z_W;
   localparam int CW     = vesg_pkg::COORD_W;

   localparam logic [CW-1:0] LIM_X = CW'(MAX_X);
   localparam logic [CW-1:0] LIM_Y = CW'(MAX_Y);
   localparam logic [CW-1:0] LIM_Z = CW'(MAX_Z);

   logic [vesg_pkg::EXT_X_W-1:0] ext_x_ff;
   logic [vesg_pkg::EXT_Y_W-1:0] ext_y_ff;
   logic [vesg_pkg::EXT_Z_W-1:0] ext_z_ff;

   logic [CW-1:0]        ux, uy, uz;
   logic [CW-1:0]        ex, ey, ez;
   logic [CW-1:0]        lx, ly, lz;
   logic                 in_grid;
   logic [ADDR_W-1:0]    cell_addr;
   logic [STEP_BITS-1:0] step_cut;

   logic                 accept;
   logic                 take;
   logic                 clear_start;
   vesg_pkg::op_type     op;

   logic                 can_take;
   logic                 sweep_busy;
   logic [ADDR_W-1:0]    sweep_addr;
   logic                 upd_wr_en;
   logic [ADDR_W-1:0]    upd_wr_addr;
   logic [STEP_BITS-1:0] upd_wr_data;
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [STEP_BITS-1:0] mem_wr_data;
   logic [STEP_BITS-1:0] rd_data;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= vesg_pkg::EXT_X_RESET;
         ext_y_ff <= vesg_pkg::EXT_Y_RESET;
         ext_z_ff <= vesg_pkg::EXT_Z_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            vesg_pkg::CSR_EXTENT_X: ext_x_ff <= csr_ch.data[vesg_pkg::EXT_X_W-1:0];
            vesg_pkg::CSR_EXTENT_Y: ext_y_ff <= csr_ch.data[vesg_pkg::EXT_Y_W-1:0];
            vesg_pkg::CSR_EXTENT_Z: ext_z_ff <= csr_ch.data[vesg_pkg::EXT_Z_W-1:0];
            default: ;
         endcase
      end
   end

   // voxel location: extents above the grid size act as the grid size
   assign ux = req_ch.voxel_x;
   assign uy = req_ch.voxel_y;
   assign uz = req_ch.voxel_z;
   assign ex = CW'(ext_x_ff);
   assign ey = CW'(ext_y_ff);
   assign ez = CW'(ext_z_ff);
   assign lx = (ex > LIM_X) ? LIM_X : ex;
   assign ly = (ey > LIM_Y) ? LIM_Y : ey;
   assign lz = (ez > LIM_Z) ? LIM_Z : ez;

   assign in_grid = !ux[CW-1] && (ux < lx)
                 && !uy[CW-1] && (uy < ly)
                 && !uz[CW-1] && (uz < lz);

   assign cell_addr = {ux[X_W-1:0], uy[Y_W-1:0], uz[Z_W-1:0]};
   assign step_cut  = STEP_BITS'(req_ch.step_value);

   // intake
   assign req_ch.ready = !sweep_busy && can_take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      op          = '0;
      op.in_grid  = in_grid;
      op.run_end  = req_ch.run_end;
      clear_start = 1'b0;
      case (req_ch.req_type)
         vesg_pkg::REQ_CLEAR:  clear_start  = accept;
         vesg_pkg::REQ_RECORD: op.is_record = 1'b1;
         vesg_pkg::REQ_QUERY:  op.is_query  = 1'b1;
         default: ;
      endcase
   end

   assign take = accept && (op.is_record || op.is_query);

   vesg_sweep #(
      .ADDR_W (ADDR_W)
   ) u_sweep (
      .clock (clock),
      .reset (reset),
      .start (clear_start),
      .busy  (sweep_busy),
      .addr  (sweep_addr)
   );

   vesg_update #(
      .ADDR_W    (ADDR_W),
      .STEP_BITS (STEP_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .op_in     (op),
      .addr_in   (cell_addr),
      .step_in   (step_cut),
      .rd_data   (rd_data),
      .rsp_ready (rsp_ch.ready),
      .can_take  (can_take),
      .wr_en     (upd_wr_en),
      .wr_addr   (upd_wr_addr),
      .wr_data   (upd_wr_data),
      .rsp_valid (rsp_ch.valid),
      .rsp_step  (rsp_ch.earliest_step)
   );

   // the sweep never overlaps an item in flight
   assign mem_wr_en   = sweep_busy || upd_wr_en;
   assign mem_wr_addr = sweep_busy ? sweep_addr : upd_wr_addr;
   assign mem_wr_data = sweep_busy ? {STEP_BITS{1'b1}} : upd_wr_data;

   vesg_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (STEP_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (cell_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

@@ rtl/vesg_checker.sv @@
`default_nettype none
`include "voxel_earliest_step_grid_macros.svh"
module vesg_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [vesg_pkg::REQ_W-1:0]       req_type,
   input wire logic                             req_run_end,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [vesg_pkg::OUT_W-1:0]       rsp_step
);

   logic req_take;
   logic rsp_stall;
   logic clear_take;
   logic end_take;

   assign req_take   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign clear_take = req_take && (req_type == vesg_pkg::REQ_CLEAR);
   assign end_take   = req_take && (req_type == vesg_pkg::REQ_QUERY) && req_run_end;

   // result register is written after the item passes the item stage register
   `VESG_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_step), "result not held")
   `VESG_ASSERT_NOW(a_reset_sweep, clock, reset, $fell(reset), !req_ready, "taken in reset sweep")
   `VESG_ASSERT_NEXT(a_clear_blocks, clock, reset, clear_take, !req_ready, "taken during clear")
   `VESG_ASSERT_NEXT(a_run_end_emits, clock, reset, end_take, ##1 rsp_valid, "run end gave no result")

endmodule

bind voxel_earliest_step_grid vesg_checker u_vesg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_type    (req_ch.req_type),
   .req_run_end (req_ch.run_end),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_step    (rsp_ch.earliest_step)
);
`default_nettype wire

@@ test/voxel_earliest_step_grid_tb.sv @@
`timescale 1ns / 1ps
module voxel_earliest_step_grid_tb;

   localparam int GRID_X = 32;
   localparam int GRID_Y = 32;
   localparam int GRID_Z = 16;
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [vesg_pkg::REQ_W-1:0]       REQ_UNUSED = 2'd3;
   localparam logic [vesg_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [vesg_pkg::REQ_W-1:0]          kind;
      logic signed [vesg_pkg::COORD_W-1:0] x;
      logic signed [vesg_pkg::COORD_W-1:0] y;
      logic signed [vesg_pkg::COORD_W-1:0] z;
      logic [vesg_pkg::STEP_IN_W-1:0]      step;
      logic                                run_end;
   } voxel_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vesg_req_if req_ch();
   vesg_rsp_if rsp_ch();
   vesg_csr_if csr_ch();

   voxel_earliest_step_grid i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [vesg_pkg::STEP_IN_W-1:0] step_grid [0:CELLS-1];
   logic [vesg_pkg::STEP_IN_W-1:0] run_min;
   logic [vesg_pkg::EXT_X_W-1:0]   ext_x;
   logic [vesg_pkg::EXT_Y_W-1:0]   ext_y;
   logic [vesg_pkg::EXT_Z_W-1:0]   ext_z;

   voxel_req_type                  pending_items[$];
   logic [vesg_pkg::OUT_W-1:0]     expected_minima[$];
   voxel_req_type                  on_wire;

   int  items_pushed = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  csr_writes = 0;
   int  grid_clears = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   logic no_idle = 1'b0;

   function automatic int clamp_extent(input int e, input int max_cells);
      return (e > max_cells) ? max_cells : e;
   endfunction

   function automatic logic locate(input voxel_req_type it, output int cell_idx);
      int x, y, z;
      x = int'(it.x);
      y = int'(it.y);
      z = int'(it.z);
      cell_idx = 0;
      if (x < 0 || x >= clamp_extent(int'(ext_x), GRID_X)) return 1'b0;
      if (y < 0 || y >= clamp_extent(int'(ext_y), GRID_Y)) return 1'b0;
      if (z < 0 || z >= clamp_extent(int'(ext_z), GRID_Z)) return 1'b0;
      cell_idx = (x * GRID_Y + y) * GRID_Z + z;
      return 1'b1;
   endfunction

   task automatic wipe_grid();
      foreach (step_grid[i]) step_grid[i] = '1;
   endtask

   task automatic predict_minimum(input voxel_req_type it);
      int   cell_idx;
      logic hit;
      case (it.kind)
         vesg_pkg::REQ_CLEAR: begin
            wipe_grid();
            grid_clears++;
         end
         vesg_pkg::REQ_RECORD: begin
            hit = locate(it, cell_idx);
            if (hit && it.step < step_grid[cell_idx]) step_grid[cell_idx] = it.step;
         end
         vesg_pkg::REQ_QUERY: begin
            hit = locate(it, cell_idx);
            if (hit && step_grid[cell_idx] < run_min) run_min = step_grid[cell_idx];
            if (it.run_end) begin
               expected_minima = {expected_minima, run_min};
               run_min = '1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_minimum(on_wire);
            items_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               on_wire = pending_items.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= on_wire.kind;
               req_ch.voxel_x    <= on_wire.x;
               req_ch.voxel_y    <= on_wire.y;
               req_ch.voxel_z    <= on_wire.z;
               req_ch.step_value <= on_wire.step;
               req_ch.run_end    <= on_wire.run_end;
               if (!no_idle && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      logic [vesg_pkg::OUT_W-1:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_minima.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected",
                                         rsp_ch.earliest_step));
            end else begin
               want = expected_minima.pop_front();
               results_checked++;
               if (rsp_ch.earliest_step !== want)
                  report_mismatch($sformatf("earliest_step %h, expected %h",
                                            rsp_ch.earliest_step, want));
            end
         end
         if (no_idle) begin
            rsp_ch.ready <= 1'b1;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 15);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_minima.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_item(input logic [vesg_pkg::REQ_W-1:0] kind, input int x,
                            input int y, input int z,
                            input logic [vesg_pkg::STEP_IN_W-1:0] step,
                            input logic run_end);
      voxel_req_type it;
      it.kind    = kind;
      it.x       = vesg_pkg::COORD_W'(x);
      it.y       = vesg_pkg::COORD_W'(y);
      it.z       = vesg_pkg::COORD_W'(z);
      it.step    = step;
      it.run_end = run_end;
      pending_items = {pending_items, it};
      items_pushed++;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_pushed || expected_minima.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_extent(input logic [vesg_pkg::CSR_INDEX_W-1:0] index,
                               input logic [vesg_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (index)
         vesg_pkg::CSR_EXTENT_X: ext_x = data;
         vesg_pkg::CSR_EXTENT_Y: ext_y = data;
         vesg_pkg::CSR_EXTENT_Z: ext_z = data[vesg_pkg::EXT_Z_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_ch.valid <= 1'b0;
   endtask

   // mostly a small hot corner so records and queries meet
   function automatic int rand_coord(input int span);
      int pick;
      pick = $urandom_range(0, 99);
      if (span > 0 && pick < 70) return $urandom_range(0, ((span < 4) ? span : 4) - 1);
      if (span > 0 && pick < 85) return $urandom_range(0, span - 1);
      if (pick < 92) return span + $urandom_range(0, 2);
      if (pick < 96) return -int'($urandom_range(1, 3));
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic logic [vesg_pkg::STEP_IN_W-1:0] rand_step();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(0, 1000);
      if (pick < 80) return $urandom;
      if (pick < 90) return '1;
      return '0;
   endfunction

   task automatic run_phase(input int n_items, input logic with_clear);
      int   made;
      int   pick;
      int   sx, sy, sz;
      logic ends;
      logic [vesg_pkg::REQ_W-1:0] kind;
      sx = clamp_extent(int'(ext_x), GRID_X);
      sy = clamp_extent(int'(ext_y), GRID_Y);
      sz = clamp_extent(int'(ext_z), GRID_Z);
      made = 0;
      if (with_clear)
         push_item(vesg_pkg::REQ_CLEAR, rand_coord(sx), rand_coord(sy), rand_coord(sz),
                   $urandom, 1'($urandom_range(0, 1)));
      while (made < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            push_item(REQ_UNUSED, rand_coord(sx), rand_coord(sy), rand_coord(sz),
                      $urandom, 1'($urandom_range(0, 1)));
         end else begin
            kind = (pick < 50) ? vesg_pkg::REQ_RECORD : vesg_pkg::REQ_QUERY;
            ends = (kind == vesg_pkg::REQ_QUERY) ? ($urandom_range(0, 2) == 0)
                                                 : 1'($urandom_range(0, 1));
            push_item(kind, rand_coord(sx), rand_coord(sy), rand_coord(sz), rand_step(), ends);
            made++;
         end
      end
      // close any open run so the phase drains
      push_item(vesg_pkg::REQ_QUERY, rand_coord(sx), rand_coord(sy), rand_coord(sz),
                rand_step(), 1'b1);
      wait_drained();
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.req_type   = vesg_pkg::REQ_CLEAR;
      req_ch.voxel_x    = '0;
      req_ch.voxel_y    = '0;
      req_ch.voxel_z    = '0;
      req_ch.step_value = '0;
      req_ch.run_end    = 1'b0;
      rsp_ch.ready      = 1'b1;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = vesg_pkg::CSR_EXTENT_X;
      csr_ch.data       = '0;
      wipe_grid();
      run_min = '1;
      ext_x = vesg_pkg::EXT_X_RESET;
      ext_y = vesg_pkg::EXT_Y_RESET;
      ext_z = vesg_pkg::EXT_Z_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset extents
      push_item(vesg_pkg::REQ_RECORD, 0, 0, 0, 32'd5, 1'b0);
      push_item(vesg_pkg::REQ_RECORD, 31, 31, 15, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_RECORD, 31, 31, 15, '1, 1'b1);
      push_item(vesg_pkg::REQ_RECORD, 0, 0, 0, 32'd7, 1'b0);
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 0, '1, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 31, 31, 15, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 0, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_QUERY, 31, 31, 15, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_QUERY, 1, 1, 1, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_RECORD, 32, 0, 0, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_RECORD, -2048, 2047, -2048, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_QUERY, 32, 0, 0, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 16, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 0, 32, 0, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 2047, 2047, 2047, 32'd0, 1'b1);
      push_item(REQ_UNUSED, 1, 1, 1, 32'd0, 1'b1);
      // record and clear in the middle of a run leave the running minimum alone
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 0, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_RECORD, 2, 2, 2, 32'd1, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 2, 2, 2, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 0, 32'd0, 1'b0);
      push_item(vesg_pkg::REQ_CLEAR, 0, 0, 0, '1, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 2, 2, 2, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 0, 0, 0, 32'd0, 1'b1);
      push_item(vesg_pkg::REQ_RECORD, 3, 4, 5, 32'h8000_0001, 1'b1);
      push_item(vesg_pkg::REQ_QUERY, 3, 4, 5, 32'd0, 1'b1);
      wait_drained();

      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd32);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd32);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd16);
      write_extent(CSR_UNUSED, 6'd5);
      run_phase(70, 1'b0);

      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd1);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd1);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd1);
      run_phase(60, 1'b0);

      // extents above the grid act as the grid size
      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd63);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd63);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd63);
      run_phase(80, 1'b1);

      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd0);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd5);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd5);
      run_phase(30, 1'b0);

      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd17);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd3);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd9);
      run_phase(80, 1'b1);

      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd5);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd32);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd0);
      run_phase(30, 1'b0);

      // closing stretch at full rate on both sides
      write_extent(vesg_pkg::CSR_EXTENT_X, 6'd32);
      write_extent(vesg_pkg::CSR_EXTENT_Y, 6'd32);
      write_extent(vesg_pkg::CSR_EXTENT_Z, 6'd16);
      no_idle = 1'b1;
      run_phase(60, 1'b1);

      if (expected_minima.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_minima.size()));
      $display("run covered %0d items, %0d register writes and %0d grid clears",
               items_accepted, csr_writes, grid_clears);
      $display("%0d query results compared, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
